// ===== rtl/bbn_pkg.sv =====
// Shared types and constants of the bounding box normalizer.
package bbn_pkg;

    localparam int COORD_W    = 32;
    localparam int TARGET_W   = 8;
    localparam int SCALE_W    = 31;
    localparam int EXT_W      = 32;
    localparam int DIVIDEND_W = TARGET_W + EXT_W;
    localparam int DIV_CNT_W  = 6;
    localparam int MAG_W      = COORD_W + 2;
    localparam int DIFF_W     = COORD_W + 3;
    localparam int PA_W       = MAG_W + SCALE_W - 16;
    localparam int PB_W       = MAG_W + 16;
    localparam int SUM_W      = PB_W;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS    = DIV_CNT_W'(DIVIDEND_W);
    localparam logic [TARGET_W-1:0]  TARGET_RESET = 8'd10;
    localparam logic [COORD_W-1:0]   COORD_MAX    = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0]   COORD_MIN    = 32'h8000_0000;
    localparam logic [SCALE_W-1:0]   SCALE_MAX    = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_BOUND = 2'd0,
        MODE_NORM  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOUND,
        ST_EXTENT,
        ST_DIV_LOAD,
        ST_DIV,
        ST_SCALE,
        ST_DIFF,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic latch_item;
        logic bound;
        logic clear;
        logic extent;
        logic div_load;
        logic div_step;
        logic scale_set;
        logic diff;
        logic mul;
        logic sum;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scale_ready;
        logic degen_now;
        logic div_last;
    } status_t;

endpackage

// ===== rtl/bbn_div.sv =====
// Restoring divider, one quotient bit per step cycle, quotient clamped to scale range.
module bbn_div
    import bbn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  step,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [EXT_W-1:0]      divisor,
    output logic                  last,
    output logic [SCALE_W-1:0]    quotient
);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [EXT_W-1:0]      rem_reg, rem_next;
    logic [EXT_W-1:0]      dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [EXT_W:0]        rem_shift;
    logic [EXT_W:0]        rem_sub;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_sub   = rem_shift - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = DIV_STEPS;
        end
        else if (step)
        begin
            // subtract when the shifted remainder covers the divisor
            if (!rem_sub[EXT_W])
            begin
                rem_next = rem_sub[EXT_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[EXT_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign last     = (cnt_reg == DIV_CNT_W'(1));
    assign quotient = (quo_reg[DIVIDEND_W-1:SCALE_W] != '0) ? SCALE_MAX
                                                             : quo_reg[SCALE_W-1:0];

endmodule

// ===== rtl/bbn_datapath.sv =====
// Datapath: bounds box, scale register, divider and the center-and-scale pipeline.
module bbn_datapath
    import bbn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic                cfg_wr_en,
    input  logic [TARGET_W-1:0] cfg_wr_data,
    input  logic [COORD_W-1:0]  x_in,
    input  logic [COORD_W-1:0]  y_in,
    input  logic [COORD_W-1:0]  z_in,
    output logic [COORD_W-1:0]  x_out,
    output logic [COORD_W-1:0]  y_out,
    output logic [COORD_W-1:0]  z_out,
    output logic                degenerate
);

    logic [TARGET_W-1:0]       target_reg;
    logic signed [COORD_W-1:0] pt_reg  [3];
    logic signed [COORD_W-1:0] min_reg [3];
    logic signed [COORD_W-1:0] max_reg [3];
    logic [EXT_W-1:0]          ext_reg [3];
    logic [SCALE_W-1:0]        scale_reg;
    logic                      seen_reg;
    logic                      ready_reg;
    logic                      degen_reg;

    logic                      neg_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic [PA_W-1:0]           pa_reg  [3];
    logic [PB_W-1:0]           pb_reg  [3];
    logic [COORD_W-1:0]        sat_reg [3];
    logic [COORD_W-1:0]        out_reg [3];
    logic                      degen_out_reg;

    logic signed [COORD_W-1:0] pt_in   [3];
    logic signed [COORD_W:0]   ext_wide[3];
    logic signed [DIFF_W-1:0]  diff    [3];
    logic [MAG_W-1:0]          mag     [3];
    logic [SUM_W-1:0]          sum     [3];
    logic [SUM_W-2:0]          half    [3];
    logic [COORD_W-1:0]        lim     [3];
    logic [EXT_W-1:0]          emax_xy;
    logic [EXT_W-1:0]          emax;
    logic                      degen_now;
    logic                      div_last;
    logic [SCALE_W-1:0]        quotient;

    assign pt_in[0] = x_in;
    assign pt_in[1] = y_in;
    assign pt_in[2] = z_in;

    // per-axis arithmetic
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        assign ext_wide[a] = {max_reg[a][COORD_W-1], max_reg[a]}
                           - {min_reg[a][COORD_W-1], min_reg[a]};
        // d = 2p - (max + min), exact
        assign diff[a] = {{2{pt_reg[a][COORD_W-1]}}, pt_reg[a], 1'b0}
                       - {{3{max_reg[a][COORD_W-1]}}, max_reg[a]}
                       - {{3{min_reg[a][COORD_W-1]}}, min_reg[a]};
        assign mag[a]  = diff[a][DIFF_W-1] ? MAG_W'(-diff[a]) : MAG_W'(diff[a]);
        assign sum[a]  = {1'b0, pa_reg[a]} + SUM_W'(pb_reg[a][PB_W-1:16]);
        assign half[a] = sum[a][SUM_W-1:1];
        assign lim[a]  = neg_reg[a] ? COORD_MIN : COORD_MAX;
    end

    // largest extent; only meaningful once a point has been bounded
    assign emax_xy   = (ext_reg[1] > ext_reg[0]) ? ext_reg[1] : ext_reg[0];
    assign emax      = (ext_reg[2] > emax_xy) ? ext_reg[2] : emax_xy;
    assign degen_now = !seen_reg || (emax == '0);

    bbn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load && !degen_now),
        .step     (cmd.div_step),
        .dividend ({target_reg, {EXT_W{1'b0}}}),
        .divisor  (emax),
        .last     (div_last),
        .quotient (quotient)
    );

    assign status.scale_ready = ready_reg;
    assign status.degen_now   = degen_now;
    assign status.div_last    = div_last;

    // control flags, box and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            seen_reg   <= 1'b0;
            ready_reg  <= 1'b0;
            degen_reg  <= 1'b0;
            scale_reg  <= '0;
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a] <= COORD_MAX;
                max_reg[a] <= COORD_MIN;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
            if (cmd.clear)
            begin
                seen_reg  <= 1'b0;
                ready_reg <= 1'b0;
                scale_reg <= '0;
                for (int a = 0; a < 3; a++)
                begin
                    min_reg[a] <= COORD_MAX;
                    max_reg[a] <= COORD_MIN;
                end
            end
            else if (cmd.bound)
            begin
                seen_reg  <= 1'b1;
                ready_reg <= 1'b0;
                for (int a = 0; a < 3; a++)
                begin
                    if (pt_reg[a] < min_reg[a])
                    begin
                        min_reg[a] <= pt_reg[a];
                    end
                    if (pt_reg[a] > max_reg[a])
                    begin
                        max_reg[a] <= pt_reg[a];
                    end
                end
            end
            else if (cmd.div_load && degen_now)
            begin
                // empty or flat box: latch a zero scale without dividing
                scale_reg <= '0;
                degen_reg <= 1'b1;
                ready_reg <= 1'b1;
            end
            else if (cmd.scale_set)
            begin
                scale_reg <= quotient;
                degen_reg <= 1'b0;
                ready_reg <= 1'b1;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (cmd.latch_item)
            begin
                pt_reg[a] <= pt_in[a];
            end
            if (cmd.extent)
            begin
                ext_reg[a] <= ext_wide[a][EXT_W-1:0];
            end
            if (cmd.diff)
            begin
                neg_reg[a] <= diff[a][DIFF_W-1];
                mag_reg[a] <= mag[a];
            end
            if (cmd.mul)
            begin
                pa_reg[a] <= PA_W'(mag_reg[a] * scale_reg[SCALE_W-1:16]);
                pb_reg[a] <= PB_W'(mag_reg[a] * scale_reg[15:0]);
            end
            if (cmd.sum)
            begin
                sat_reg[a] <= (half[a] > (SUM_W-1)'(lim[a])) ? lim[a]
                                                              : half[a][COORD_W-1:0];
            end
            if (cmd.load_out)
            begin
                if (degen_reg)
                begin
                    out_reg[a] <= '0;
                end
                else
                begin
                    out_reg[a] <= neg_reg[a] ? (COORD_W'(0) - sat_reg[a]) : sat_reg[a];
                end
            end
        end
        if (cmd.load_out)
        begin
            degen_out_reg <= degen_reg;
        end
    end

    assign x_out      = out_reg[0];
    assign y_out      = out_reg[1];
    assign z_out      = out_reg[2];
    assign degenerate = degen_out_reg;

endmodule

// ===== rtl/bbn_ctrl.sv =====
// Controller: item sequencing and the result valid flag.
module bbn_ctrl
    import bbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] mode,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  status_t    status,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    mode_t  item_mode;

    assign item_mode = mode_t'(mode);
    assign accept    = (state_reg == ST_IDLE) && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch_item = 1'b1;
                    case (item_mode)
                        MODE_BOUND: state_next = ST_BOUND;
                        MODE_NORM:  state_next = status.scale_ready ? ST_DIFF : ST_EXTENT;
                        MODE_CLEAR: cmd.clear  = 1'b1;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BOUND:
            begin
                cmd.bound  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EXTENT:
            begin
                cmd.extent = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = status.degen_now ? ST_DIFF : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale_set = 1'b1;
                state_next    = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/bounding_box_normalizer.sv =====
// Top level of the bounding box normalizer: controller plus datapath.
//
//   channel   direction  handshake              payload
//   request   in         in_valid / in_stall    mode, x_in, y_in, z_in
//   result    out        out_valid / out_stall  x_out, y_out, z_out, degenerate
//   config    in         cfg_wr_en              cfg_wr_data (target_extent)
//
// One request at a time. Clear and no-op requests end on acceptance, bound requests
// run the bound state. A normalize with a latched scale runs diff, multiply, sum and
// output; the first after a bound or clear adds extent, divider load, 40 divider
// steps and scale latch, or only extent and divider load for an empty or flat box.
// Reset loads target_extent = 10, an empty box and no scale. A stalled result waits
// in the output register while the next request is accepted and worked on.
module bounding_box_normalizer
    import bbn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [TARGET_W-1:0] cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [COORD_W-1:0]  x_in,
    input  logic [COORD_W-1:0]  y_in,
    input  logic [COORD_W-1:0]  z_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [COORD_W-1:0]  x_out,
    output logic [COORD_W-1:0]  y_out,
    output logic [COORD_W-1:0]  z_out,
    output logic                degenerate
);

    cmd_t    cmd;
    status_t status;

    // sequence each request and own the result valid flag
    bbn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // box, scale, divider and center-and-scale arithmetic
    bbn_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .x_in        (x_in),
        .y_in        (y_in),
        .z_in        (z_in),
        .x_out       (x_out),
        .y_out       (y_out),
        .z_out       (z_out),
        .degenerate  (degenerate)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of bounding_box_normalizer: random requests against a built-in model.
`timescale 1ns / 100ps

module tb
    import bbn_pkg::*;
();

    // Cycles to let pass once the last expected result is in, so that any request still
    // in work (one that owes no result) can finish its work.
    localparam int SETTLE_CYCLES = 64;
    // Requests per random phase, not counting no-op requests.
    localparam int PHASE_REQUESTS = 225;

    typedef struct {
        mode_t              mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pt_req_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        degen;
    } norm_res_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [TARGET_W-1:0] cfg_wr_data = '0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [1:0]          mode        = MODE_NOP;
    logic [COORD_W-1:0]  x_in        = '0;
    logic [COORD_W-1:0]  y_in        = '0;
    logic [COORD_W-1:0]  z_in        = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [COORD_W-1:0]  x_out;
    logic [COORD_W-1:0]  y_out;
    logic [COORD_W-1:0]  z_out;
    logic                degenerate;

    // Requests waiting to be offered, and normalized points still owed by the block.
    pt_req_t   point_q[$];
    norm_res_t norm_result_q[$];

    // Own copy of the block's register and box state.
    logic [7:0]         target_now;
    logic signed [31:0] box_lo_x, box_lo_y, box_lo_z;
    logic signed [31:0] box_hi_x, box_hi_y, box_hi_z;
    logic [31:0]        scale_q16;
    logic               scale_latched;
    logic               box_filled;

    // Sender and receiver bookkeeping.
    pt_req_t   cur_req;
    logic      offering      = 1'b0;
    int        gap_left      = 0;
    int        stall_left    = 0;
    int        src_idle_pct  = 0;
    int        sink_idle_pct = 0;
    logic      sink_hold     = 1'b0;
    int        accept_cnt    = 0;
    int        stim_cnt      = 0;
    int        mismatch_cnt  = 0;
    norm_res_t want;

    bounding_box_normalizer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .x_in        (x_in),
        .y_in        (y_in),
        .z_in        (z_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .x_out       (x_out),
        .y_out       (y_out),
        .z_out       (z_out),
        .degenerate  (degenerate)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Box model
    // ------------------------------------------------------------------

    // Restore an empty box: min at the top of the range, max at the bottom.
    function automatic void empty_box();
        box_lo_x      = COORD_MAX;
        box_lo_y      = COORD_MAX;
        box_lo_z      = COORD_MAX;
        box_hi_x      = COORD_MIN;
        box_hi_y      = COORD_MIN;
        box_hi_z      = COORD_MIN;
        scale_q16     = '0;
        scale_latched = 1'b0;
        box_filled    = 1'b0;
    endfunction

    // Center one coordinate on the box and scale it. The offset is kept doubled
    // (2p - (hi + lo)) so that it stays exact; the extra factor of two is taken out
    // together with the Q16.16 shift. Truncate toward zero, then saturate.
    function automatic logic [31:0] center_scale(logic signed [31:0] p,
                                                 logic signed [31:0] lo,
                                                 logic signed [31:0] hi);
        longint          dbl;
        longint unsigned mag;
        longint unsigned prod_hi;
        longint unsigned prod_lo;
        longint unsigned r;
        dbl     = 2 * longint'(p) - (longint'(hi) + longint'(lo));
        mag     = (dbl < 0) ? longint'(-dbl) : longint'(dbl);
        prod_hi = mag * (scale_q16 >> 16);
        prod_lo = mag * (scale_q16 & 32'h0000_FFFF);
        r       = (prod_hi + (prod_lo >> 16)) >> 1;
        if (dbl >= 0)
        begin
            if (r > 64'h7FFF_FFFF)
                r = 64'h7FFF_FFFF;
        end
        else
        begin
            if (r > 64'h8000_0000)
                r = 64'h8000_0000;
            r = -r;
        end
        return r[31:0];
    endfunction

    // Advance the model by one accepted request; queue the point it owes, if any.
    function automatic void apply_request(pt_req_t r);
        longint          ex, ey, ez, ext;
        longint unsigned quo;
        logic            degen;
        norm_res_t       res;
        case (r.mode)
            MODE_BOUND:
            begin
                if (r.x < box_lo_x) box_lo_x = r.x;
                if (r.y < box_lo_y) box_lo_y = r.y;
                if (r.z < box_lo_z) box_lo_z = r.z;
                if (r.x > box_hi_x) box_hi_x = r.x;
                if (r.y > box_hi_y) box_hi_y = r.y;
                if (r.z > box_hi_z) box_hi_z = r.z;
                box_filled    = 1'b1;
                scale_latched = 1'b0;
            end
            MODE_CLEAR: empty_box();
            MODE_NORM:
            begin
                ex  = longint'(box_hi_x) - longint'(box_lo_x);
                ey  = longint'(box_hi_y) - longint'(box_lo_y);
                ez  = longint'(box_hi_z) - longint'(box_lo_z);
                ext = ex;
                if (ey > ext) ext = ey;
                if (ez > ext) ext = ez;
                if (!box_filled)
                    ext = 0;
                degen = !box_filled || (ext <= 0);
                // Latch the scale on the first normalize request of a pass only.
                if (!scale_latched)
                begin
                    if (degen)
                        scale_q16 = '0;
                    else
                    begin
                        quo = {24'b0, target_now, 32'b0} / longint'(ext);
                        if (quo > 64'h7FFF_FFFF)
                            quo = 64'h7FFF_FFFF;
                        scale_q16 = quo[31:0];
                    end
                    scale_latched = 1'b1;
                end
                res.degen = degen;
                if (degen)
                begin
                    res.x = '0;
                    res.y = '0;
                    res.z = '0;
                end
                else
                begin
                    res.x = center_scale(r.x, box_lo_x, box_hi_x);
                    res.y = center_scale(r.y, box_lo_y, box_hi_y);
                    res.z = center_scale(r.z, box_lo_z, box_hi_z);
                end
                norm_result_q.insert(norm_result_q.size(), res);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Helpers for both sides
    // ------------------------------------------------------------------

    // Idle length: none for (100 - pct) percent of calls, otherwise short, now and then long.
    function automatic int pick_gap(int pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll >= pct)
            return 0;
        if (roll < pct / 8)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    // Print one line per mismatch (the first few dozen only), count all of them.
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
    endtask

    // ------------------------------------------------------------------
    // Request driver: offer queued requests, hold each one until accepted
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode     <= MODE_NOP;
            x_in     <= '0;
            y_in     <= '0;
            z_in     <= '0;
            cur_req  = '{MODE_NOP, 32'sd0, 32'sd0, 32'sd0};
            offering = 1'b0;
            gap_left = 0;
        end
        else
        begin
            // Accepted at this edge: predict it and start an idle gap.
            if (offering && !in_stall)
            begin
                apply_request(cur_req);
                accept_cnt++;
                offering = 1'b0;
                gap_left = pick_gap(src_idle_pct);
            end
            // Fetch the next request once the gap has run out.
            if (!offering)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (point_q.size() > 0)
                begin
                    cur_req  = point_q.pop_front();
                    offering = 1'b1;
                end
            end
            // One assignment per signal per edge; the payload holds while stalled.
            in_valid <= offering;
            mode     <= cur_req.mode;
            x_in     <= cur_req.x;
            y_in     <= cur_req.y;
            z_in     <= cur_req.z;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each accepted result, stall at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (norm_result_q.size() == 0)
                    report_mismatch("result with no request pending", x_out, '0);
                else
                begin
                    want = norm_result_q.pop_front();
                    if (x_out !== want.x)
                        report_mismatch("x_out", x_out, want.x);
                    if (y_out !== want.y)
                        report_mismatch("y_out", y_out, want.y);
                    if (z_out !== want.z)
                        report_mismatch("z_out", z_out, want.z);
                    if (degenerate !== want.degen)
                        report_mismatch("degenerate", 32'(degenerate), 32'(want.degen));
                end
            end
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap(sink_idle_pct);
            out_stall <= sink_hold || (stall_left > 0);
        end
    end

    // Hold off the receiver for a long stretch while requests keep coming, so that
    // the output register fills and the block stalls its request side.
    initial
    begin
        do
            @(negedge clk);
        while (accept_cnt < 600 || point_q.size() < 40);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (400) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // Give up after a fixed time: the slowest correct run takes a small fraction of it.
    initial
    begin
        #15_000_000;
        $display("** bounding_box_normalizer: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_req(mode_t m, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        pt_req_t req;
        req = '{m, px, py, pz};
        point_q.insert(point_q.size(), req);
        if (m != MODE_NOP)
            stim_cnt++;
    endtask

    // Coordinate of a given flavor: anywhere, small, extreme, or clustered on a base.
    function automatic logic [31:0] pick_coord(int kind, logic [31:0] base);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            2:
            begin
                case ($urandom_range(0, 6))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    4:       return 32'h0000_0001;
                    5:       return COORD_MIN + 1;
                    default: return COORD_MAX - 1;
                endcase
            end
            default: return base + $urandom_range(0, 3);
        endcase
    endfunction

    // One well-formed two-pass cloud: bound its points, then normalize points of it
    // (or stray ones), now and then widening the box in the middle of the pass.
    task automatic push_cloud();
        logic [31:0] bx, by, bz;
        logic [31:0] px, py, pz;
        int          kind, n_bound, n_norm, pick;
        pt_req_t     entry;
        pt_req_t     cloud[$];
        kind = $urandom_range(0, 3);
        bx   = $urandom;
        by   = $urandom;
        bz   = $urandom;
        if ($urandom_range(0, 1))
            push_req(MODE_CLEAR, $urandom, $urandom, $urandom);
        n_bound = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 8);
        n_norm  = $urandom_range(1, 10);
        repeat (n_bound)
        begin
            px = pick_coord(kind, bx);
            py = pick_coord(kind, by);
            pz = pick_coord(kind, bz);
            push_req(MODE_BOUND, px, py, pz);
            entry = '{MODE_BOUND, px, py, pz};
            cloud.insert(cloud.size(), entry);
        end
        for (int k = 0; k < n_norm; k++)
        begin
            if (k > 0 && $urandom_range(0, 9) == 0)
                push_req(MODE_BOUND, pick_coord(kind, bx), pick_coord(kind, by),
                         pick_coord(kind, bz));
            if ($urandom_range(0, 9) < 6)
            begin
                pick = $urandom_range(0, cloud.size() - 1);
                push_req(MODE_NORM, cloud[pick].x, cloud[pick].y, cloud[pick].z);
            end
            else
                push_req(MODE_NORM, pick_coord(kind, bx), pick_coord(kind, by),
                         pick_coord(kind, bz));
        end
    endtask

    // A short burst of arbitrary requests, no-ops included.
    task automatic push_noise();
        int kind;
        repeat ($urandom_range(1, 6))
        begin
            kind = $urandom_range(0, 2);
            push_req(mode_t'($urandom_range(0, 3)), pick_coord(kind, 0), pick_coord(kind, 0),
                     pick_coord(kind, 0));
        end
    endtask

    // Wait until every queued request is accepted and every result has come back,
    // then let any request that owes no result finish its work.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (point_q.size() != 0 || offering || norm_result_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write target_extent; only call with the block idle.
    task automatic write_target(logic [7:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        target_now  = value;
    endtask

    initial
    begin
        target_now = TARGET_RESET;
        empty_box();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, target at its reset value with no idling.
        // Normalize on an empty box, a no-op, then a box of a single point (flat).
        push_req(MODE_NORM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_req(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(MODE_BOUND, 32'h0005_0000, 32'hFFFD_0000, 32'h0007_0000);
        push_req(MODE_NORM, 32'h0005_0000, 32'hFFFD_0000, 32'h0007_0000);
        // Full-range box: the widest extent there is.
        push_req(MODE_BOUND, COORD_MIN, COORD_MAX, 32'h0000_0000);
        push_req(MODE_BOUND, COORD_MAX, COORD_MIN, 32'h0001_0000);
        push_req(MODE_NORM, COORD_MAX, COORD_MIN, 32'h0000_0000);
        push_req(MODE_NORM, COORD_MIN, COORD_MAX, 32'hFFFF_FFFF);
        // Clear and build an 8.0-wide box, latch its scale at target 10.
        push_req(MODE_CLEAR, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_req(MODE_BOUND, 32'hFFFC_0000, 32'h0000_0000, 32'h0000_0000);
        push_req(MODE_BOUND, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
        push_req(MODE_NORM, 32'h0004_0000, 32'h0000_8000, 32'h0001_0000);
        push_req(MODE_NORM, COORD_MAX, COORD_MIN, 32'h0000_0001);
        wait_drained();

        // Change the target in the middle of a pass: the latched scale must stay,
        // and the next bound request starts a pass that picks up the new target.
        write_target(8'd200);
        push_req(MODE_NORM, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_4000);
        push_req(MODE_BOUND, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_req(MODE_NORM, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_4000);
        // One-LSB box: the scale saturates and so do the x and y outputs, one of each sign.
        push_req(MODE_CLEAR, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_req(MODE_BOUND, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_req(MODE_BOUND, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        push_req(MODE_NORM, COORD_MAX, COORD_MIN, 32'h0000_0001);
        wait_drained();

        // Zero target: zero scale, zero outputs, not degenerate.
        write_target(8'd0);
        push_req(MODE_BOUND, 32'h0005_0000, 32'h0000_0000, 32'hFFF0_0000);
        push_req(MODE_NORM, COORD_MAX, COORD_MIN, 32'h1234_5678);
        // Cleared box is degenerate again.
        push_req(MODE_CLEAR, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_req(MODE_NORM, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        wait_drained();

        // Random phases, each with its own target and idling mix; the first and last run
        // without idling, the rest with more sender and less receiver idling each phase.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       write_target(8'd255);
                1:       write_target(8'd1);
                5:       write_target(TARGET_RESET);
                default: write_target(8'($urandom_range(1, 255)));
            endcase
            src_idle_pct  = (ph == 0 || ph == 5) ? 0 : 15 * ph;
            sink_idle_pct = (ph == 0 || ph == 5) ? 0 : 75 - 15 * ph;
            stim_cnt      = 0;
            while (stim_cnt < PHASE_REQUESTS)
            begin
                if ($urandom_range(0, 9) < 8)
                    push_cloud();
                else
                    push_noise();
            end
            wait_drained();
        end

        if (mismatch_cnt == 0)
            $display("** bounding_box_normalizer: PASSED **");
        else
            $display("** bounding_box_normalizer: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bbn_pkg.sv
rtl/bbn_div.sv
rtl/bbn_datapath.sv
rtl/bbn_ctrl.sv
rtl/bounding_box_normalizer.sv
bench/tb.sv
